// ===== rtl/ppke_pkg.sv =====
// Package for the pulse parameter key editor: request and response types, key codes, bounds.
package ppke_pkg;

   // Request and response payloads
   typedef struct packed {
      logic       func;
      logic [2:0] key;
      logic [7:0] stored_scale;
      logic [7:0] stored_period;
      logic [7:0] stored_width;
   } req_type;

   typedef struct packed {
      logic [3:0] scale;
      logic [7:0] period;
      logic [7:0] width;
      logic [1:0] field_sel;
      logic       refresh;
      logic       save;
   } rsp_type;

   // Request functions
   localparam logic FUNC_POLL = 1'b0;
   localparam logic FUNC_LOAD = 1'b1;

   // Key codes
   localparam logic [2:0] KEY_NONE  = 3'd0;
   localparam logic [2:0] KEY_LEFT  = 3'd1;
   localparam logic [2:0] KEY_RIGHT = 3'd2;
   localparam logic [2:0] KEY_UP    = 3'd3;
   localparam logic [2:0] KEY_DOWN  = 3'd4;

   // Selected field codes
   localparam logic [1:0] SEL_PERIOD = 2'd0;
   localparam logic [1:0] SEL_WIDTH  = 2'd1;
   localparam logic [1:0] SEL_SCALE  = 2'd2;
   localparam logic [1:0] SEL_SPARE  = 2'd3;

   // Bounds and defaults
   localparam logic [3:0] SCALE_MAX      = 4'd14;
   localparam logic [7:0] SCALE_LOAD_MAX = 8'd14;
   localparam logic [7:0] PERIOD_MAX     = 8'd255;
   localparam logic [7:0] PERIOD_MIN     = 8'd10;
   localparam logic [7:0] WIDTH_MIN      = 8'd1;
   localparam logic [7:0] PERIOD_DEF     = 8'd200;
   localparam logic [7:0] WIDTH_DEF      = 8'd10;
   localparam logic [7:0] STORED_BLANK   = 8'hff;
   localparam logic [6:0] SAVE_DELAY_RST = 7'd100;

endpackage

// ===== rtl/pulse_param_key_editor.sv =====
// Top level of the pulse parameter key editor: settings registers, key logic, response buffer.
//
// Usage
//   req_*  : one request per key poll (func 0) or per load of stored bytes (func 1).
//   rsp_*  : exactly one response per request, in request order, carrying the current
//            scale, period, width, selected field and the refresh and save flags.
//   csr_*  : write of save_delay (7 bit); csr_ready is always high. Write only while idle.
// Response : each response is registered into the response buffer when its request is accepted.
// Throughput: one request per cycle while req_ready is high; the settings update in a single pass of short
//            logic from the settings registers into a two-entry response buffer.
// Stall    : with rsp_ready low the buffer takes one more request, then req_ready
//            drops until the receiver takes a response.
// Reset    : synchronous, active high; scale 0, period 200, width 10, period selected,
//            a refresh pending, save_delay 100, response buffer empty.
module pulse_param_key_editor (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ppke_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ppke_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [6:0]        csr_data
);

   // Settings and control registers
   logic [6:0] save_delay_ff;
   logic [3:0] scale_ff,   scale_in;
   logic [7:0] period_ff,  period_in;
   logic [7:0] width_ff,   width_in;
   logic [1:0] sel_ff,     sel_in;
   logic [2:0] last_key_ff, last_key_in;
   logic       pending_ff, pending_in;
   logic [6:0] idle_ff,    idle_in;
   logic       refresh_flag;
   logic       save_flag;

   // Response buffer: head slot and one spare slot
   ppke_pkg::rsp_type head_ff, spare_ff, rsp_new;
   logic [1:0]        count_ff;
   logic              push;
   logic              pop;

   assign req_ready = (count_ff != 2'd2);
   assign push      = req_valid && req_ready;
   assign rsp_valid = (count_ff != 2'd0);
   assign pop       = rsp_valid && rsp_ready;
   assign rsp_data  = head_ff;
   assign csr_ready = 1'b1;

   // Next settings for the request at the port
   always_comb begin
      logic [7:0] p;
      logic [7:0] w;
      logic [7:0] p_dec;
      logic       pend;
      logic [6:0] idle;
      scale_in     = scale_ff;
      period_in    = period_ff;
      width_in     = width_ff;
      sel_in       = sel_ff;
      last_key_in  = last_key_ff;
      pending_in   = pending_ff;
      idle_in      = idle_ff;
      refresh_flag = 1'b0;
      save_flag    = 1'b0;
      p            = req_data.stored_period;
      w            = req_data.stored_width;
      p_dec        = period_ff - 8'd1;
      pend         = pending_ff;
      idle         = idle_ff;
      if (req_data.func == ppke_pkg::FUNC_LOAD) begin
         // Load: check stored bytes, blank store gives the defaults
         scale_in = (req_data.stored_scale > ppke_pkg::SCALE_LOAD_MAX) ?
                    4'd0 : req_data.stored_scale[3:0];
         if (p == ppke_pkg::STORED_BLANK && w == ppke_pkg::STORED_BLANK) begin
            p = ppke_pkg::PERIOD_DEF;
            w = ppke_pkg::WIDTH_DEF;
         end
         if (w >= p) begin
            w = p - 8'd1;
         end
         period_in  = p;
         width_in   = w;
         pending_in = 1'b1;
         idle_in    = save_delay_ff;
      end else begin
         // Poll: a key acts only on a change
         if (req_data.key != last_key_ff) begin
            case (req_data.key)
               ppke_pkg::KEY_LEFT: begin
                  sel_in = (sel_ff >= ppke_pkg::SEL_SCALE) ? ppke_pkg::SEL_PERIOD :
                           sel_ff + 2'd1;
                  pend = 1'b1;
               end
               ppke_pkg::KEY_RIGHT: begin
                  sel_in = (sel_ff == ppke_pkg::SEL_PERIOD || sel_ff == ppke_pkg::SEL_SPARE) ?
                           ppke_pkg::SEL_SCALE : sel_ff - 2'd1;
                  pend = 1'b1;
               end
               ppke_pkg::KEY_UP: begin
                  pend = 1'b0;
                  case (sel_ff)
                     ppke_pkg::SEL_PERIOD: begin
                        if (period_ff < ppke_pkg::PERIOD_MAX) begin
                           period_in = period_ff + 8'd1;
                           pend      = 1'b1;
                        end
                     end
                     ppke_pkg::SEL_WIDTH: begin
                        if (period_ff != 8'd0 && width_ff < p_dec) begin
                           width_in = width_ff + 8'd1;
                           pend     = 1'b1;
                        end
                     end
                     ppke_pkg::SEL_SCALE: begin
                        if (scale_ff < ppke_pkg::SCALE_MAX) begin
                           scale_in = scale_ff + 4'd1;
                           pend     = 1'b1;
                        end
                     end
                     default: begin
                        pend = 1'b0;
                     end
                  endcase
               end
               ppke_pkg::KEY_DOWN: begin
                  pend = 1'b0;
                  case (sel_ff)
                     ppke_pkg::SEL_PERIOD: begin
                        if (period_ff > ppke_pkg::PERIOD_MIN) begin
                           period_in = p_dec;
                           width_in  = (width_ff >= p_dec) ? p_dec - 8'd1 : width_ff;
                           pend      = 1'b1;
                        end
                     end
                     ppke_pkg::SEL_WIDTH: begin
                        if (width_ff > ppke_pkg::WIDTH_MIN) begin
                           width_in = width_ff - 8'd1;
                           pend     = 1'b1;
                        end
                     end
                     ppke_pkg::SEL_SCALE: begin
                        if (scale_ff != 4'd0) begin
                           scale_in = scale_ff - 4'd1;
                           pend     = 1'b1;
                        end
                     end
                     default: begin
                        pend = 1'b0;
                     end
                  endcase
               end
               default: begin
                  pend = pending_ff;
               end
            endcase
         end
         // Refresh restarts the idle count; save once the count meets the delay
         if (pend) begin
            refresh_flag = 1'b1;
            pend         = 1'b0;
            idle         = 7'd0;
         end
         if (idle < save_delay_ff) begin
            idle      = idle + 7'd1;
            save_flag = (idle == save_delay_ff);
         end
         last_key_in = req_data.key;
         pending_in  = pend;
         idle_in     = idle;
      end
   end

   // Response built from the updated settings
   always_comb begin
      rsp_new.scale     = scale_in;
      rsp_new.period    = period_in;
      rsp_new.width     = width_in;
      rsp_new.field_sel = sel_in;
      rsp_new.refresh   = refresh_flag;
      rsp_new.save      = save_flag;
   end

   // Settings, configuration and buffer fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         save_delay_ff <= ppke_pkg::SAVE_DELAY_RST;
         scale_ff      <= 4'd0;
         period_ff     <= ppke_pkg::PERIOD_DEF;
         width_ff      <= ppke_pkg::WIDTH_DEF;
         sel_ff        <= ppke_pkg::SEL_PERIOD;
         last_key_ff   <= ppke_pkg::KEY_NONE;
         pending_ff    <= 1'b1;
         idle_ff       <= ppke_pkg::SAVE_DELAY_RST;
         count_ff      <= 2'd0;
      end else begin
         if (csr_valid) begin
            save_delay_ff <= csr_data;
         end
         if (push) begin
            scale_ff    <= scale_in;
            period_ff   <= period_in;
            width_ff    <= width_in;
            sel_ff      <= sel_in;
            last_key_ff <= last_key_in;
            pending_ff  <= pending_in;
            idle_ff     <= idle_in;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 2'd1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 2'd1;
         end
      end
   end

   // Response buffer payload
   always_ff @(posedge clock) begin
      case (count_ff)
         2'd0: begin
            if (push) begin
               head_ff <= rsp_new;
            end
         end
         2'd1: begin
            if (push && pop) begin
               head_ff <= rsp_new;
            end else if (push) begin
               spare_ff <= rsp_new;
            end
         end
         2'd2: begin
            if (pop) begin
               head_ff <= spare_ff;
            end
         end
         default: begin
            head_ff <= head_ff;
         end
      endcase
   end

endmodule

// ===== rtl/ppke_checker.sv =====
// Port checker for the pulse parameter key editor, bound to the top level.
module ppke_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input ppke_pkg::rsp_type rsp_data
);

   // A stalled response stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // A stalled response keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_data))
      else $error("response payload changed while stalled");

   // Selector and scale stay within their ranges
   a_ranges: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.field_sel != ppke_pkg::SEL_SPARE) &&
                    (rsp_data.scale <= ppke_pkg::SCALE_MAX))
      else $error("selector or scale out of range");

endmodule

bind pulse_param_key_editor ppke_checker u_ppke_checker (.*);
